[rtl/biu_pkg.sv]
// Shared types and constants for the bilinear image upscaler.
package biu_pkg;

   localparam int COORD_W   = 12;
   localparam int CH_W      = 8;
   localparam int IN_DIM_W  = 9;
   localparam int OUT_DIM_W = 13;
   localparam int PIX_W     = 3 * CH_W;

   localparam logic [CH_W-1:0] CHAN_MAX = 8'd255;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] REG_IN_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IN_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
   localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

   typedef struct packed {
      logic               operation;
      logic [COORD_W-1:0] x_coord;
      logic [COORD_W-1:0] y_coord;
      logic [CH_W-1:0]    red_in;
      logic [CH_W-1:0]    green_in;
      logic [CH_W-1:0]    blue_in;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
      logic [CH_W-1:0] alpha_out;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

[rtl/biu_divider.sv]
// Restoring divider, one quotient bit per cycle.
module biu_divider
   import biu_pkg::*;
#(
   parameter int NUM_W = 36,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output div_ctl_type      status,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quot_ff <= numer;
            rem_ff  <= '0;
            den_ff  <= denom;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (cnt_ff != '0) begin
            rem_ff  <= fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
            quot_ff <= {quot_ff[NUM_W-2:0], fits};
            cnt_ff  <= cnt_ff - CNT_W'(1);
            done_ff <= (cnt_ff == CNT_W'(1));
         end
      end
   end

   assign quot          = quot_ff;
   assign status.start  = start;
   assign status.done   = done_ff;

   busy_start: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff > CNT_W'(1)) |=> !done_ff)
      else $error("divider finished early");

endmodule

[rtl/biu_frame_mem.sv]
// Single-port frame store with registered read data.
module biu_frame_mem #(
   parameter int DEPTH  = 65536,
   parameter int DATA_W = 24
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/bilinear_image_upscaler_core.sv]
// Top level: bilinear RGB upscaler with frame store, CSRs and sequencer.
//
//   channel | ports                          | direction | payload
//   req     | req_valid, req_stall, req_data | in        | req_type
//   rsp     | rsp_valid, rsp_stall, rsp_data | out       | rsp_type
//   csr     | psel .. prdata                 | in/out    | 32-bit regs
//
// A load writes the frame store at its transfer when its coordinates are in range.
// A query holds req_stall while the two position dividers run at one quotient
// bit per cycle, through the split, the four frame store reads and the last
// accumulate, and until the result is loaded.
// An earlier result still stalled on rsp holds a finished query until it leaves.
// Synchronous reset clears control and sets the CSRs to their defaults; the frame store is not cleared.
module bilinear_image_upscaler_core
   import biu_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = 256,
   parameter int MAX_SRC_HEIGHT = 256,
   parameter int FRAC_BITS      = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW     = $clog2(MAX_SRC_WIDTH);
   localparam int RW     = $clog2(MAX_SRC_HEIGHT);
   localparam int SRC_AW = (CW > RW) ? CW : RW;
   localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int NUM_CW = COORD_W + SRC_AW + FRAC_BITS;
   localparam int NUM_RW = COORD_W + SRC_AW + FRAC_BITS;
   localparam int WF_W   = FRAC_BITS + 1;
   localparam int WT_W   = 2 * FRAC_BITS + 1;
   localparam int ACC_W  = 2 * FRAC_BITS + CH_W + 2;
   localparam logic [WF_W-1:0] ONE_FX = WF_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_SPLIT, ST_RD, ST_FIN} state_type;

   state_type               state_ff;
   logic [IN_DIM_W-1:0]     in_width_ff, in_height_ff;
   logic [OUT_DIM_W-1:0]    out_width_ff, out_height_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   logic [RW-1:0]           fr_ff, cr_ff;
   logic [CW-1:0]           fc_ff, cc_ff;
   logic [WF_W-1:0]         a_ff, b_ff;
   logic [2:0]              rd_cnt_ff;
   logic                    acc_en_ff;
   logic [WT_W-1:0]         wt_ff;
   logic [ACC_W-1:0]        acc_r_ff, acc_g_ff, acc_b_ff;

   logic [OUT_DIM_W-1:0]    w_eff, h_eff, ow_eff, oh_eff;
   logic [CW-1:0]           w_m1;
   logic [RW-1:0]           h_m1;
   logic                    req_xfer, load_ok, cfg_wr, rsp_free;
   logic [NUM_RW-1:0]       num_row, quot_row;
   logic [NUM_CW-1:0]       num_col, quot_col;
   div_ctl_type             div_row_st, div_col_st;
   logic [NUM_RW-FRAC_BITS-1:0] flr_r, cel_r;
   logic [NUM_CW-FRAC_BITS-1:0] flr_c, cel_c;
   logic [FRAC_BITS-1:0]    frac_r, frac_c;
   logic [WF_W-1:0]         wa, wb;
   logic [1:0]              k;
   logic                    mem_en, mem_we;
   logic [AW-1:0]           mem_addr;
   logic [PIX_W-1:0]        mem_rdata;
   logic [RW-1:0]           rd_row;
   logic [CW-1:0]           rd_col;
   logic [ACC_W-FRAC_BITS*2-1:0] sr, sg, sb;

   always_comb begin
      w_eff  = (in_width_ff == '0) ? OUT_DIM_W'(1) :
               (OUT_DIM_W'(in_width_ff) > OUT_DIM_W'(MAX_SRC_WIDTH)) ?
               OUT_DIM_W'(MAX_SRC_WIDTH) : OUT_DIM_W'(in_width_ff);
      h_eff  = (in_height_ff == '0) ? OUT_DIM_W'(1) :
               (OUT_DIM_W'(in_height_ff) > OUT_DIM_W'(MAX_SRC_HEIGHT)) ?
               OUT_DIM_W'(MAX_SRC_HEIGHT) : OUT_DIM_W'(in_height_ff);
      ow_eff = (out_width_ff == '0) ? OUT_DIM_W'(1) : out_width_ff;
      oh_eff = (out_height_ff == '0) ? OUT_DIM_W'(1) : out_height_ff;
      w_m1   = CW'(w_eff - OUT_DIM_W'(1));
      h_m1   = RW'(h_eff - OUT_DIM_W'(1));
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign load_ok   = (OUT_DIM_W'(req_data.x_coord) < w_eff) &&
                      (OUT_DIM_W'(req_data.y_coord) < h_eff);
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign num_row = (NUM_RW'(req_data.y_coord) * NUM_RW'(h_m1)) << FRAC_BITS;
   assign num_col = (NUM_CW'(req_data.x_coord) * NUM_CW'(w_m1)) << FRAC_BITS;

   biu_divider #(.NUM_W(NUM_RW), .DEN_W(OUT_DIM_W)) u_div_row (
      .clock(clock), .reset(reset),
      .start(req_xfer && req_data.operation == OP_QUERY),
      .numer(num_row), .denom(oh_eff), .status(div_row_st), .quot(quot_row)
   );

   biu_divider #(.NUM_W(NUM_CW), .DEN_W(OUT_DIM_W)) u_div_col (
      .clock(clock), .reset(reset),
      .start(req_xfer && req_data.operation == OP_QUERY),
      .numer(num_col), .denom(ow_eff), .status(div_col_st), .quot(quot_col)
   );

   always_comb begin
      frac_r = quot_row[FRAC_BITS-1:0];
      frac_c = quot_col[FRAC_BITS-1:0];
      flr_r  = quot_row[NUM_RW-1:FRAC_BITS];
      flr_c  = quot_col[NUM_CW-1:FRAC_BITS];
      cel_r  = flr_r + ((frac_r != '0) ? 1'b1 : 1'b0);
      cel_c  = flr_c + ((frac_c != '0) ? 1'b1 : 1'b0);
      k      = rd_cnt_ff[1:0];
      wa     = k[0] ? ONE_FX - a_ff : a_ff;
      wb     = k[1] ? ONE_FX - b_ff : b_ff;
      rd_row = k[0] ? cr_ff : fr_ff;
      rd_col = k[1] ? cc_ff : fc_ff;
      mem_en = 1'b0;
      mem_we = 1'b0;
      if (state_ff == ST_IDLE) begin
         mem_en   = req_xfer && req_data.operation == OP_LOAD && load_ok;
         mem_we   = 1'b1;
         mem_addr = AW'(RW'(req_data.y_coord)) * AW'(MAX_SRC_WIDTH) +
                    AW'(CW'(req_data.x_coord));
      end else begin
         mem_en   = (state_ff == ST_RD) && !rd_cnt_ff[2];
         mem_addr = AW'(rd_row) * AW'(MAX_SRC_WIDTH) + AW'(rd_col);
      end
      sr = acc_r_ff[ACC_W-1:2*FRAC_BITS];
      sg = acc_g_ff[ACC_W-1:2*FRAC_BITS];
      sb = acc_b_ff[ACC_W-1:2*FRAC_BITS];
   end

   biu_frame_mem #(.DEPTH(DEPTH), .DATA_W(PIX_W)) u_mem (
      .clock(clock), .en(mem_en), .we(mem_we), .addr(mem_addr),
      .wdata({req_data.red_in, req_data.green_in, req_data.blue_in}),
      .rdata(mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_width_ff   <= IN_DIM_W'(256);
         in_height_ff  <= IN_DIM_W'(256);
         out_width_ff  <= OUT_DIM_W'(512);
         out_height_ff <= OUT_DIM_W'(2048);
         rsp_valid_ff  <= 1'b0;
         rd_cnt_ff     <= '0;
         acc_en_ff     <= 1'b0;
      end else begin
         if (cfg_wr) begin
            case (paddr[3:2])
               REG_IN_WIDTH:   in_width_ff   <= pwdata[IN_DIM_W-1:0];
               REG_IN_HEIGHT:  in_height_ff  <= pwdata[IN_DIM_W-1:0];
               REG_OUT_WIDTH:  out_width_ff  <= pwdata[OUT_DIM_W-1:0];
               REG_OUT_HEIGHT: out_height_ff <= pwdata[OUT_DIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         acc_en_ff <= 1'b0;
         if (acc_en_ff) begin
            acc_r_ff <= acc_r_ff +
                        ACC_W'(wt_ff) * ACC_W'(mem_rdata[3*CH_W-1:2*CH_W]);
            acc_g_ff <= acc_g_ff +
                        ACC_W'(wt_ff) * ACC_W'(mem_rdata[2*CH_W-1:CH_W]);
            acc_b_ff <= acc_b_ff +
                        ACC_W'(wt_ff) * ACC_W'(mem_rdata[CH_W-1:0]);
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer && req_data.operation == OP_QUERY) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_row_st.done) begin
                  state_ff <= ST_SPLIT;
               end
            end
            ST_SPLIT: begin
               fr_ff     <= (flr_r > (NUM_RW-FRAC_BITS)'(h_m1)) ? h_m1 : RW'(flr_r);
               cr_ff     <= (cel_r > (NUM_RW-FRAC_BITS)'(h_m1)) ? h_m1 : RW'(cel_r);
               fc_ff     <= (flr_c > (NUM_CW-FRAC_BITS)'(w_m1)) ? w_m1 : CW'(flr_c);
               cc_ff     <= (cel_c > (NUM_CW-FRAC_BITS)'(w_m1)) ? w_m1 : CW'(cel_c);
               a_ff      <= (frac_r != '0) ? ONE_FX - WF_W'(frac_r) : '0;
               b_ff      <= (frac_c != '0) ? ONE_FX - WF_W'(frac_c) : '0;
               acc_r_ff  <= '0;
               acc_g_ff  <= '0;
               acc_b_ff  <= '0;
               rd_cnt_ff <= '0;
               state_ff  <= ST_RD;
            end
            ST_RD: begin
               if (!rd_cnt_ff[2]) begin
                  wt_ff     <= WT_W'(wa) * WT_W'(wb);
                  acc_en_ff <= 1'b1;
                  rd_cnt_ff <= rd_cnt_ff + 3'(1);
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (rsp_free) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_data_ff.red_out   <= (sr > CHAN_MAX) ? CHAN_MAX : CH_W'(sr);
                  rsp_data_ff.green_out <= (sg > CHAN_MAX) ? CHAN_MAX : CH_W'(sg);
                  rsp_data_ff.blue_out  <= (sb > CHAN_MAX) ? CHAN_MAX : CH_W'(sb);
                  rsp_data_ff.alpha_out <= CHAN_MAX;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_IN_WIDTH:   prdata = 32'(in_width_ff);
         REG_IN_HEIGHT:  prdata = 32'(in_height_ff);
         REG_OUT_WIDTH:  prdata = 32'(out_width_ff);
         REG_OUT_HEIGHT: prdata = 32'(out_height_ff);
         default:        prdata = '0;
      endcase
   end

   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_free) |=> rsp_valid_ff)
      else $error("result not loaded on finish");

   wr_idle: assert property (@(posedge clock) disable iff (reset)
      (mem_en && state_ff != ST_IDLE) |-> !mem_we)
      else $error("frame store write during query");

   div_sync: assert property (@(posedge clock) disable iff (reset)
      div_row_st.done |-> (div_col_st.done && state_ff == ST_DIV))
      else $error("dividers out of step");

   cnt_range: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff[2] |-> (rd_cnt_ff[1:0] == 2'b00))
      else $error("read counter overrun");

endmodule

[test/tb_bilinear_image_upscaler_core.sv]
// Self-checking testbench for the bilinear image upscaler core.
`timescale 1ns / 100ps

module tb_bilinear_image_upscaler_core
   import biu_pkg::*;
();

   localparam int SRC_W = 256;
   localparam int SRC_H = 256;
   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      req_type req;
      logic    has_known;
      rsp_type known;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   logic [PIX_W-1:0] pixel_mem [SRC_W*SRC_H];
   bit               pixel_written [SRC_W*SRC_H];
   int               cfg_in_w, cfg_in_h, cfg_out_w, cfg_out_h;
   rsp_type          pixel_queue [$];
   int               error_count = 0;
   int               result_count = 0;
   int               load_count = 0;
   int               idle_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   bilinear_image_upscaler_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic int eff_dim(int v, int max_v);
      if (v < 1) return 1;
      if (v > max_v) return max_v;
      return v;
   endfunction

   function automatic void split_coord(input int coord, input int n_in, input int n_out,
                                       output int lo, output int hi, output longint wt);
      longint pos, f, fl, cl, den;
      den = (n_out == 0) ? 1 : n_out;
      pos = ((longint'(coord) * (n_in - 1)) << FRAC) / den;
      f = pos & ((64'd1 << FRAC) - 1);
      fl = pos >> FRAC;
      cl = fl + (f != 0 ? 1 : 0);
      lo = (fl > n_in - 1) ? n_in - 1 : int'(fl);
      hi = (cl > n_in - 1) ? n_in - 1 : int'(cl);
      wt = (f != 0) ? (64'd1 << FRAC) - f : 0;
   endfunction

   function automatic rsp_type interpolate_pixel(int x, int y);
      int w, h, fr, cr, fc, cc;
      longint a, b, one, wff, wcf, wfc, wcc, s;
      logic [PIX_W-1:0] pff, pcf, pfc, pcc;
      rsp_type r;
      w = eff_dim(cfg_in_w, SRC_W);
      h = eff_dim(cfg_in_h, SRC_H);
      one = 64'd1 << FRAC;
      split_coord(y, h, cfg_out_h, fr, cr, a);
      split_coord(x, w, cfg_out_w, fc, cc, b);
      wff = a * b;
      wcf = (one - a) * b;
      wfc = a * (one - b);
      wcc = (one - a) * (one - b);
      pff = pixel_mem[fr*SRC_W+fc];
      pcf = pixel_mem[cr*SRC_W+fc];
      pfc = pixel_mem[fr*SRC_W+cc];
      pcc = pixel_mem[cr*SRC_W+cc];
      for (int ch = 0; ch < 3; ch++) begin
         int sh;
         sh = 16 - 8 * ch;
         s = wff * ((pff >> sh) & 8'hFF) + wcf * ((pcf >> sh) & 8'hFF)
           + wfc * ((pfc >> sh) & 8'hFF) + wcc * ((pcc >> sh) & 8'hFF);
         s = s >> (2 * FRAC);
         if (s > 255) s = 255;
         case (ch)
            0: r.red_out = s[7:0];
            1: r.green_out = s[7:0];
            default: r.blue_out = s[7:0];
         endcase
      end
      r.alpha_out = CHAN_MAX;
      return r;
   endfunction

   // true when all four neighbors of a query have been loaded
   function automatic bit query_covered(int x, int y);
      int w, h, fr, cr, fc, cc;
      longint a, b;
      w = eff_dim(cfg_in_w, SRC_W);
      h = eff_dim(cfg_in_h, SRC_H);
      split_coord(y, h, cfg_out_h, fr, cr, a);
      split_coord(x, w, cfg_out_w, fc, cc, b);
      return pixel_written[fr*SRC_W+fc] && pixel_written[cr*SRC_W+fc] &&
             pixel_written[fr*SRC_W+cc] && pixel_written[cr*SRC_W+cc];
   endfunction

   task automatic report_mismatch(input string what, input rsp_type got,
                                  input rsp_type want);
      $display("MISMATCH %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_count <= 0;
         else
            idle_count <= idle_count + 1;
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (pixel_queue.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_data, '0);
            end else begin
               rsp_type want;
               want = pixel_queue.pop_front();
               if (rsp_data.red_out !== want.red_out ||
                   rsp_data.green_out !== want.green_out ||
                   rsp_data.blue_out !== want.blue_out ||
                   rsp_data.alpha_out !== want.alpha_out)
                  report_mismatch("pixel", rsp_data, want);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results pending", pixel_queue.size());
         $display("bilinear_image_upscaler_core test failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input int value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_IN_WIDTH: cfg_in_w = value & 9'h1FF;
         REG_IN_HEIGHT: cfg_in_h = value & 9'h1FF;
         REG_OUT_WIDTH: cfg_out_w = value & 13'h1FFF;
         default: cfg_out_h = value & 13'h1FFF;
      endcase
   endtask

   task automatic wait_drained();
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(input req_type item);
      int w, h;
      while ($urandom_range(99) < send_idle_pct) begin
         @(posedge clock);
         req_valid <= 1'b0;
      end
      @(posedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      w = eff_dim(cfg_in_w, SRC_W);
      h = eff_dim(cfg_in_h, SRC_H);
      if (item.operation == OP_LOAD) begin
         if (item.x_coord < w && item.y_coord < h) begin
            pixel_mem[item.y_coord*SRC_W+item.x_coord] =
               {item.red_in, item.green_in, item.blue_in};
            pixel_written[item.y_coord*SRC_W+item.x_coord] = 1'b1;
            load_count++;
         end
      end else begin
         pixel_queue.push_back(interpolate_pixel(item.x_coord, item.y_coord));
      end
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
   endtask

   // req_valid is lowered after each transfer; the next send re-raises it at a
   // later clock edge, so no signal sees two assignments in one step
   function automatic req_type make_item(logic op, int x, int y, int r, int g, int b);
      req_type it;
      it.operation = op;
      it.x_coord = COORD_W'(x);
      it.y_coord = COORD_W'(y);
      it.red_in = CH_W'(r);
      it.green_in = CH_W'(g);
      it.blue_in = CH_W'(b);
      return it;
   endfunction

   task automatic load_image(input int w, input int h);
      for (int yy = 0; yy < h; yy++)
         for (int xx = 0; xx < w; xx++)
            send_item(make_item(OP_LOAD, xx, yy, $urandom_range(255),
                                $urandom_range(255), $urandom_range(255)));
   endtask

   // loads whichever of the four source pixels under a query are still unset
   task automatic load_neighbors(input int x, input int y);
      int w, h, fr, cr, fc, cc;
      longint a, b;
      w = eff_dim(cfg_in_w, SRC_W);
      h = eff_dim(cfg_in_h, SRC_H);
      split_coord(y, h, cfg_out_h, fr, cr, a);
      split_coord(x, w, cfg_out_w, fc, cc, b);
      for (int i = 0; i < 4; i++) begin
         int rr, cl;
         rr = i[0] ? cr : fr;
         cl = i[1] ? cc : fc;
         if (!pixel_written[rr*SRC_W+cl])
            send_item(make_item(OP_LOAD, cl, rr, $urandom_range(255),
                                $urandom_range(255), $urandom_range(255)));
      end
   endtask

   task automatic random_phase(input int w, input int h, input int ow, input int oh,
                               input int n);
      req_type it;
      csr_write(REG_IN_WIDTH, w);
      csr_write(REG_IN_HEIGHT, h);
      csr_write(REG_OUT_WIDTH, ow);
      csr_write(REG_OUT_HEIGHT, oh);
      if (eff_dim(w, SRC_W) * eff_dim(h, SRC_H) <= 64)
         load_image(eff_dim(w, SRC_W), eff_dim(h, SRC_H));
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: it = make_item(OP_LOAD, $urandom_range(4095), $urandom_range(4095),
                              $urandom_range(255), $urandom_range(255),
                              $urandom_range(255));
            1, 2: it = make_item(OP_LOAD, $urandom_range(eff_dim(w, SRC_W) - 1),
                                 $urandom_range(eff_dim(h, SRC_H) - 1),
                                 $urandom_range(255), $urandom_range(255),
                                 $urandom_range(255));
            3: it = make_item(OP_QUERY, $urandom_range(4095), $urandom_range(4095),
                              $urandom_range(255), $urandom_range(255),
                              $urandom_range(255));
            default: it = make_item(OP_QUERY, $urandom_range(ow),
                                    $urandom_range(oh), $urandom_range(255),
                                    $urandom_range(255), $urandom_range(255));
         endcase
         if (it.operation == OP_QUERY && !query_covered(it.x_coord, it.y_coord))
            load_neighbors(it.x_coord, it.y_coord);
         send_item(it);
      end
      wait_drained();
   endtask

   initial begin
      table_row_type rows [$];
      table_row_type row;
      rsp_type white;
      int phase;
      for (int i = 0; i < SRC_W*SRC_H; i++) begin
         pixel_mem[i] = '0;
         pixel_written[i] = 1'b0;
      end
      cfg_in_w = 256;
      cfg_in_h = 256;
      cfg_out_w = 512;
      cfg_out_h = 2048;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: 2x2 source, extreme corners and out-of-range cases
      csr_write(REG_IN_WIDTH, 2);
      csr_write(REG_IN_HEIGHT, 2);
      csr_write(REG_OUT_WIDTH, 4);
      csr_write(REG_OUT_HEIGHT, 4);
      white = {CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX};
      rows.push_back('{make_item(OP_LOAD, 0, 0, 255, 255, 255), 0, '0});
      rows.push_back('{make_item(OP_LOAD, 1, 0, 0, 0, 0), 0, '0});
      rows.push_back('{make_item(OP_LOAD, 0, 1, 255, 0, 128), 0, '0});
      rows.push_back('{make_item(OP_LOAD, 1, 1, 0, 255, 127), 0, '0});
      rows.push_back('{make_item(OP_LOAD, 2, 0, 1, 2, 3), 0, '0});
      rows.push_back('{make_item(OP_LOAD, 4095, 4095, 9, 9, 9), 0, '0});
      rows.push_back('{make_item(OP_QUERY, 0, 0, 0, 0, 0), 1, white});
      rows.push_back('{make_item(OP_QUERY, 1, 1, 0, 0, 0), 0, '0});
      rows.push_back('{make_item(OP_QUERY, 2, 3, 0, 0, 0), 0, '0});
      rows.push_back('{make_item(OP_QUERY, 4095, 4095, 255, 255, 255), 0, '0});
      rows.push_back('{make_item(OP_QUERY, 4095, 0, 0, 0, 0), 0, '0});
      foreach (rows[i]) begin
         row = rows[i];
         if (row.req.operation == OP_QUERY && row.has_known) begin
            if (interpolate_pixel(row.req.x_coord, row.req.y_coord) != row.known)
               report_mismatch("table row", interpolate_pixel(row.req.x_coord,
                               row.req.y_coord), row.known);
         end
         send_item(row.req);
      end
      wait_drained();

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 88 : 0;
         recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 35 : 0;
         random_phase(1, 1, 1, 1, 40);
         random_phase(256, 256, 4096, 4096, 20);
         random_phase(5, 3, 17, 9, 40);
         random_phase(0, 0, 0, 0, 20);
         random_phase(4, 7, 4, 7, 40);
      end
      recv_idle_pct = 0;
      wait_drained();

      $display("covered %0d results and %0d in-range loads over 15 size settings",
               result_count, load_count);
      $display("with sender and receiver idling in both orders and none");
      if (error_count == 0)
         $display("bilinear_image_upscaler_core test passed");
      else
         $display("bilinear_image_upscaler_core test failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/biu_pkg.sv
rtl/biu_divider.sv
rtl/biu_frame_mem.sv
rtl/bilinear_image_upscaler_core.sv
test/tb_bilinear_image_upscaler_core.sv
